FILE: hw/rtl/frame_scramble_conv_interleave_defines.svh
// Assertion helpers used by the top-level RTL file.
`ifndef FRAME_SCRAMBLE_CONV_INTERLEAVE_DEFINES_SVH
`define FRAME_SCRAMBLE_CONV_INTERLEAVE_DEFINES_SVH

// Checked while reset is low.
`define FSCI_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define FSCI_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/fsci_pkg.sv
package fsci_pkg;

  localparam logic [7:0] SEED_RESET = 8'hFF;
  localparam logic [6:0] G1_MASK    = 7'h4F;
  localparam logic [6:0] G2_MASK    = 7'h6D;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_READ = 1'b1;

  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_NOT_READY = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE      = 4'b0001,
    ST_RD_WAIT   = 4'b0010,
    ST_ENC_FETCH = 4'b0100,
    ST_ENC_BIT   = 4'b1000
  } state_t;

  typedef struct packed {
    logic clear;
    logic step;
    logic second;
  } conv_ctrl_t;

  // returns {next register, randomizer byte}
  function automatic logic [15:0] rand_step(input logic [7:0] st_in);
    logic [7:0] st;
    logic [7:0] rnd;
    logic       fb;
    st  = st_in;
    rnd = '0;
    for (int k = 7; k >= 0; k--) begin
      fb     = st[7] ^ st[6] ^ st[4] ^ st[2];
      rnd[k] = st[7];
      st     = {st[6:0], fb};
    end
    return {st, rnd};
  endfunction

endpackage

FILE: hw/rtl/fsci_ram.sv
module fsci_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 134
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/fsci_conv.sv
module fsci_conv #(
  parameter int ROWS  = 32,
  parameter int COLS  = 67,
  parameter int POS_W = 12
) (
  input  logic                 clk,
  input  logic                 rst,
  input  fsci_pkg::conv_ctrl_t ctrl,
  input  logic                 in_bit,
  output logic                 code_bit,
  output logic [POS_W-1:0]     pos
);

  localparam int ROW_W = $clog2(ROWS);
  localparam int COL_W = $clog2(COLS + 1);

  logic [5:0]       sr;
  logic [ROW_W-1:0] row;
  logic [COL_W-1:0] col;
  logic [6:0]       taps;

  assign taps     = {in_bit, sr};
  assign code_bit = ctrl.second ? ^(taps & fsci_pkg::G2_MASK) : ^(taps & fsci_pkg::G1_MASK);

  // interleave address walks down a column, then moves to the next one
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      sr  <= '0;
      row <= '0;
      col <= '0;
      pos <= '0;
    end else if (ctrl.step) begin
      if (ctrl.second) begin
        sr <= {sr[4:0], in_bit};
      end
      if (row == ROW_W'(ROWS - 1)) begin
        row <= '0;
        col <= col + COL_W'(1);
        pos <= POS_W'(col) + POS_W'(1);
      end else begin
        row <= row + ROW_W'(1);
        pos <= pos + POS_W'(COLS);
      end
    end
  end

endmodule

FILE: hw/rtl/frame_scramble_conv_interleave.sv
// Frame randomizer, K=7 rate-1/2 convolutional encoder and bit interleaver.
// Input stream: tuser is the mode (0 = load payload byte, 1 = read encoded byte),
// tdata the payload byte. Output stream: tdata the encoded byte, tlast marks the
// final byte of a frame, tuser is the status (1 = no encoded frame ready).
// The cfg channel writes the randomizer seed; it is always ready and takes effect
// at the next frame start.
// A load gives no output word. The last load of a frame starts the encoder: one byte
// fetch plus sixteen code bits per byte through the shared encoder/interleave unit,
// with the input not ready.
// A read gives one output word through the registered bit-bank read, then the output
// register. Input is taken only while the output register is empty or being emptied,
// so a stalled receiver holds off further items.
// Reset returns to the loading phase, empties the output register and sets the
// seed to 0xFF. The code bit store has no clearing pass.
`include "frame_scramble_conv_interleave_defines.svh"

module frame_scramble_conv_interleave #(
  parameter int FRAME_LEN_BYTES = 134,
  parameter int INTERLEAVE_ROWS = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,  // data_byte
  input  logic       s_axis_tuser,  // mode
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,  // encoded_byte
  output logic       m_axis_tlast,  // last_byte
  output logic       m_axis_tuser,  // status
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  localparam int CODE_BITS  = FRAME_LEN_BYTES * 16;
  localparam int COLS       = (CODE_BITS + INTERLEAVE_ROWS - 1) / INTERLEAVE_ROWS;
  localparam int STORE_BITS = INTERLEAVE_ROWS * COLS;
  localparam int OUT_BYTES  = FRAME_LEN_BYTES * 2;
  localparam int BANK_DEPTH = (STORE_BITS + 7) / 8;
  localparam int POS_W      = $clog2(STORE_BITS + 1);
  localparam int BA_W       = $clog2(BANK_DEPTH);
  localparam int CNT_W      = $clog2(FRAME_LEN_BYTES);
  localparam int RC_W       = $clog2(OUT_BYTES);

  fsci_pkg::state_t     state;
  fsci_pkg::conv_ctrl_t conv_ctrl;

  logic             phase_rd;
  logic [CNT_W-1:0] load_count;
  logic [CNT_W-1:0] enc_byte;
  logic [RC_W-1:0]  read_count;
  logic [3:0]       cnt;
  logic [7:0]       seed;
  logic [7:0]       rand_reg;
  logic             rd_nr;
  logic             rd_last;

  logic             in_acc;
  logic             is_read;
  logic             load_acc;
  logic             read_acc;
  logic             load_last;
  logic [CNT_W-1:0] scr_waddr;
  logic [15:0]      rnd;
  logic [7:0]       scr_q;
  logic [7:0]       bank_q;
  logic             code_bit;
  logic [POS_W-1:0] pos;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == fsci_pkg::ST_IDLE) && (!m_axis_tvalid || m_axis_tready);

  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign is_read   = (s_axis_tuser == fsci_pkg::MODE_READ);
  assign load_acc  = in_acc && !is_read;
  assign read_acc  = in_acc && is_read;
  assign scr_waddr = phase_rd ? '0 : load_count;
  assign load_last = (scr_waddr == CNT_W'(FRAME_LEN_BYTES - 1));
  assign rnd       = fsci_pkg::rand_step((scr_waddr == '0) ? seed : rand_reg);

  assign conv_ctrl.clear  = load_acc && load_last;
  assign conv_ctrl.step   = (state == fsci_pkg::ST_ENC_BIT);
  assign conv_ctrl.second = !cnt[0];

  fsci_ram #(
    .WIDTH(8),
    .DEPTH(FRAME_LEN_BYTES)
  ) u_scr_ram (
    .clk   (clk),
    .we    (load_acc),
    .waddr (scr_waddr),
    .wdata (s_axis_tdata ^ rnd[7:0]),
    .re    (state == fsci_pkg::ST_ENC_FETCH),
    .raddr (enc_byte),
    .rdata (scr_q)
  );

  fsci_conv #(
    .ROWS  (INTERLEAVE_ROWS),
    .COLS  (COLS),
    .POS_W (POS_W)
  ) u_conv (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (conv_ctrl),
    .in_bit   (scr_q[cnt[3:1]]),
    .code_bit (code_bit),
    .pos      (pos)
  );

  // bit n of an output byte lives in bank n
  for (genvar j = 0; j < 8; j++) begin : g_bank
    fsci_ram #(
      .WIDTH(1),
      .DEPTH(BANK_DEPTH)
    ) u_bank (
      .clk   (clk),
      .we    (conv_ctrl.step && (pos[2:0] == 3'(j))),
      .waddr (BA_W'(pos >> 3)),
      .wdata (code_bit),
      .re    (read_acc),
      .raddr (BA_W'(read_count)),
      .rdata (bank_q[j])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= fsci_pkg::ST_IDLE;
      phase_rd      <= 1'b0;
      load_count    <= '0;
      read_count    <= '0;
      enc_byte      <= '0;
      cnt           <= '0;
      seed          <= fsci_pkg::SEED_RESET;
      rand_reg      <= fsci_pkg::SEED_RESET;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        seed <= cfg_data;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        fsci_pkg::ST_IDLE: begin
          if (load_acc) begin
            rand_reg   <= rnd[15:8];
            read_count <= '0;
            phase_rd   <= 1'b0;
            if (load_last) begin
              load_count <= '0;
              enc_byte   <= CNT_W'(FRAME_LEN_BYTES - 1);
              state      <= fsci_pkg::ST_ENC_FETCH;
            end else begin
              load_count <= scr_waddr + CNT_W'(1);
            end
          end else if (read_acc) begin
            rd_nr   <= !phase_rd;
            rd_last <= (read_count == RC_W'(OUT_BYTES - 1));
            if (phase_rd) begin
              if (read_count == RC_W'(OUT_BYTES - 1)) begin
                read_count <= '0;
                phase_rd   <= 1'b0;
              end else begin
                read_count <= read_count + RC_W'(1);
              end
            end
            state <= fsci_pkg::ST_RD_WAIT;
          end
        end
        fsci_pkg::ST_RD_WAIT: begin
          m_axis_tvalid <= 1'b1;
          m_axis_tdata  <= rd_nr ? 8'd0 : bank_q;
          m_axis_tlast  <= !rd_nr && rd_last;
          m_axis_tuser  <= rd_nr ? fsci_pkg::STATUS_NOT_READY : fsci_pkg::STATUS_OK;
          state         <= fsci_pkg::ST_IDLE;
        end
        fsci_pkg::ST_ENC_FETCH: begin
          cnt   <= 4'd15;
          state <= fsci_pkg::ST_ENC_BIT;
        end
        fsci_pkg::ST_ENC_BIT: begin
          cnt <= cnt - 4'd1;
          if (cnt == 4'd0) begin
            if (enc_byte == '0) begin
              phase_rd <= 1'b1;
              state    <= fsci_pkg::ST_IDLE;
            end else begin
              enc_byte <= enc_byte - CNT_W'(1);
              state    <= fsci_pkg::ST_ENC_FETCH;
            end
          end
        end
        default: begin
          state <= fsci_pkg::ST_IDLE;
        end
      endcase
    end
  end

  `FSCI_ASSERT(a_read_gives_word, clk, rst, read_acc |=> ##1 m_axis_tvalid, "read gave no word")
  `FSCI_ASSERT(a_not_ready_word, clk, rst, (m_axis_tvalid && m_axis_tuser) |-> (!m_axis_tlast && m_axis_tdata == 8'd0), "bad not_ready word")
  `FSCI_ASSERT(a_last_load_encodes, clk, rst, (load_acc && load_last) |=> (state == fsci_pkg::ST_ENC_FETCH), "encoder not started")
  `FSCI_ASSERT(a_phase_from_encode, clk, rst, $rose(phase_rd) |-> ($past(state) == fsci_pkg::ST_ENC_BIT), "readout opened outside encode")
  `FSCI_ASSERT_ALWAYS(a_reset_clears, clk, rst |=> (!m_axis_tvalid && state == fsci_pkg::ST_IDLE), "reset left block busy")

endmodule
